@@ src/pidaw_pkg.sv @@
// pidaw_pkg: shared types and register codes for the pid controller with anti-windup
// no dependencies; imported by every module of the block

package pidaw_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCUM_LIMIT = 3'd4;

    localparam int CFG_DATA_W = 32;

    // input action codes
    localparam logic ACTION_UPDATE = 1'b0;
    localparam logic ACTION_CLEAR  = 1'b1;

    // configuration register file contents
    typedef struct packed {
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [14:0] drive_limit;
        logic [30:0] accum_limit;
    } cfg_t;

    // one update word
    typedef struct packed {
        logic        action;
        logic [15:0] setpoint;
        logic [15:0] measured;
    } item_t;

    // controller state as seen from outside the core
    typedef struct packed {
        logic [31:0] accum;
        logic [16:0] prev_error;
        logic [15:0] prev_drive;
    } stat_t;

endpackage

@@ src/pid_controller_antiwindup.sv @@
// pid_controller_antiwindup: positional pid step with conditional-integration anti-windup
// path: an accepted word is registered in the input stage, then its result is pushed into the output buffer
// throughput: one word per cycle while the result buffer has room; the integral, its 16x32 product and the output
//   clamp close combinationally through the state registers, which sets that rate
// reset: rst_n clears gains, limits, integral, last error, last output and the buffers
// depends on pidaw_pkg, pidaw_cfg, pidaw_core and pidaw_out_buf

module pid_controller_antiwindup (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [31:0]                        s_tdata,   // [15:0] setpoint, [31:16] measured
    input  logic [0:0]                         s_tuser,   // [0] action
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata,   // [15:0] drive
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pidaw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pidaw_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pidaw_pkg::*;

    cfg_t        cfg;
    stat_t       stat;
    item_t       item_reg;
    logic        in_valid_reg, in_valid_next;
    logic        advance;
    logic        space;
    logic [15:0] drive;

    // input stage moves on whenever the result buffer has room
    assign advance       = in_valid_reg && space;
    assign s_tready      = !in_valid_reg || advance;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.action   <= s_tuser[0];
            item_reg.setpoint <= s_tdata[15:0];
            item_reg.measured <= s_tdata[31:16];
        end
    end

    pidaw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pidaw_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .drive   (drive),
        .stat    (stat)
    );

    pidaw_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .push_data (drive),
        .space     (space),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // a clear word produces a zero result
    a_clear_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_reg.action == ACTION_CLEAR |-> drive == 16'd0)
        else $error("clear word produced a nonzero drive");

    // a clear word leaves the controller state zeroed
    a_clear_zero_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_reg.action == ACTION_CLEAR |=>
            stat.accum == 32'd0 && stat.prev_error == 17'd0 && stat.prev_drive == 16'd0)
        else $error("clear word left state behind");

    // with a limit set the result stays within it
    a_drive_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        advance && cfg.drive_limit != '0 |->
            $signed(drive) <= $signed({1'b0, cfg.drive_limit}) &&
            $signed(drive) >= -$signed({1'b0, cfg.drive_limit}))
        else $error("drive outside the output limit");

    // the stored result equals what was last accepted into the state
    a_state_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> stat.prev_drive == $past(drive))
        else $error("last drive state does not match the pushed result");

endmodule

@@ src/pidaw_cfg.sv @@
// pidaw_cfg: configuration register file, one write word per cycle
// depends on pidaw_pkg for register codes and cfg_t

module pidaw_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pidaw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pidaw_pkg::CFG_DATA_W-1:0]   cfg_data,
    output pidaw_pkg::cfg_t                    cfg
);
    import pidaw_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // register write decode, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_GAIN_P:      cfg_next.gain_p      = cfg_data[15:0];
                REG_GAIN_I:      cfg_next.gain_i      = cfg_data[15:0];
                REG_GAIN_D:      cfg_next.gain_d      = cfg_data[15:0];
                REG_DRIVE_LIMIT: cfg_next.drive_limit = cfg_data[14:0];
                REG_ACCUM_LIMIT: cfg_next.accum_limit = cfg_data[30:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

endmodule

@@ src/pidaw_core.sv @@
// pidaw_core: combinational pid datapath and controller state registers
// depends on pidaw_pkg for cfg_t, item_t and stat_t

module pidaw_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  pidaw_pkg::item_t  item,
    input  pidaw_pkg::cfg_t   cfg,
    output logic [15:0]       drive,
    output pidaw_pkg::stat_t  stat
);
    import pidaw_pkg::*;

    logic signed [31:0] accum_reg, accum_next;
    logic signed [16:0] prev_error_reg, prev_error_next;
    logic signed [15:0] prev_drive_reg, prev_drive_next;

    logic signed [15:0] setpoint, measured;
    logic signed [15:0] gain_p, gain_i, gain_d;
    logic signed [16:0] err;
    logic        [16:0] drive_mag;
    logic               integrate;
    logic signed [32:0] acc_sum;
    logic signed [31:0] acc_sat;
    logic signed [31:0] acc_int;
    logic signed [32:0] acc_wide;
    logic signed [32:0] acc_lim;
    logic signed [31:0] acc_new;
    logic signed [32:0] p_prod;
    logic signed [47:0] i_prod;
    logic signed [17:0] err_diff;
    logic signed [33:0] d_prod;
    logic signed [41:0] sum;
    logic signed [41:0] drv_lim;
    logic signed [41:0] sum_clamp;
    logic signed [15:0] sum_sat;

    assign setpoint = $signed(item.setpoint);
    assign measured = $signed(item.measured);
    assign gain_p   = $signed(cfg.gain_p);
    assign gain_i   = $signed(cfg.gain_i);
    assign gain_d   = $signed(cfg.gain_d);

    // error and integration gate from the previous output magnitude
    always_comb
    begin
        err       = 17'(setpoint) - 17'(measured);
        drive_mag = prev_drive_reg[15] ? (17'd0 - 17'(prev_drive_reg)) : 17'(prev_drive_reg);
        integrate = drive_mag < {2'b00, cfg.drive_limit};
    end

    // integral update: gated saturating add, then symmetric clamp when a limit is set
    always_comb
    begin
        acc_sum = 33'(accum_reg) + 33'(err);
        if (acc_sum[32] != acc_sum[31])
            acc_sat = acc_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            acc_sat = acc_sum[31:0];
        acc_int  = integrate ? acc_sat : accum_reg;
        acc_wide = 33'(acc_int);
        acc_lim  = $signed({2'b00, cfg.accum_limit});
        acc_new  = acc_int;
        if (cfg.accum_limit != '0)
        begin
            if (acc_wide > acc_lim)
                acc_new = acc_lim[31:0];
            else if (acc_wide < -acc_lim)
                acc_new = 32'(-acc_lim);
        end
    end

    // gain products, each floored by the q8.8 shift
    always_comb
    begin
        p_prod   = 33'(gain_p) * 33'(err);
        i_prod   = 48'(gain_i) * 48'(acc_new);
        err_diff = 18'(err) - 18'(prev_error_reg);
        d_prod   = 34'(gain_d) * 34'(err_diff);
        sum      = 42'($signed(p_prod[32:8])) + 42'($signed(i_prod[47:8]))
                 + 42'($signed(d_prod[33:8]));
    end

    // output clamp and 16-bit saturation
    always_comb
    begin
        drv_lim   = $signed({27'd0, cfg.drive_limit});
        sum_clamp = sum;
        if (cfg.drive_limit != '0)
        begin
            if (sum > drv_lim)
                sum_clamp = drv_lim;
            else if (sum < -drv_lim)
                sum_clamp = -drv_lim;
        end
        if (sum_clamp > 42'sd32767)
            sum_sat = 16'sh7FFF;
        else if (sum_clamp < -42'sd32768)
            sum_sat = 16'sh8000;
        else
            sum_sat = sum_clamp[15:0];
    end

    // next state, clear action zeroes everything
    always_comb
    begin
        if (item.action == ACTION_CLEAR)
        begin
            accum_next      = '0;
            prev_error_next = '0;
            prev_drive_next = '0;
        end
        else
        begin
            accum_next      = acc_new;
            prev_error_next = err;
            prev_drive_next = sum_sat;
        end
    end

    assign drive = prev_drive_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg      <= '0;
            prev_error_reg <= '0;
            prev_drive_reg <= '0;
        end
        else if (advance)
        begin
            accum_reg      <= accum_next;
            prev_error_reg <= prev_error_next;
            prev_drive_reg <= prev_drive_next;
        end
    end

    assign stat.accum      = accum_reg;
    assign stat.prev_error = prev_error_reg;
    assign stat.prev_drive = prev_drive_reg;

endmodule

@@ src/pidaw_out_buf.sv @@
// pidaw_out_buf: two-entry result buffer between the datapath and the master side
// depends on pidaw_pkg only through the shared import convention

module pidaw_out_buf (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [15:0] push_data,
    output logic        space,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // [15:0] drive
);
    import pidaw_pkg::*;

    logic [15:0] mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    assign pop      = m_tvalid && m_tready;
    assign space    = count_reg != 2'd2;
    assign m_tvalid = count_reg != 2'd0;
    assign m_tdata  = mem[rd_ptr_reg];

    // pointer and fill count bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

@@ sim/pid_drive_monitor.sv @@
// pid_drive_monitor: watches the config, update and drive channels of the pid controller,
// predicts each drive word and compares it with the block's output
// depends on pidaw_pkg for register and action codes

`timescale 1ns / 100ps

module pid_drive_monitor (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // [15:0] setpoint, [31:16] measured
    input  logic [0:0]                        s_tuser,   // [0] action
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [15:0]                       m_tdata,   // [15:0] drive
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [pidaw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pidaw_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                mismatches,
    output int                                outstanding
);
    import pidaw_pkg::*;

    localparam longint ACC_MAX = 64'sd2147483647;
    localparam longint ACC_MIN = -ACC_MAX - 1;

    // mirrored register file
    logic signed [15:0] kp = '0;
    logic signed [15:0] ki = '0;
    logic signed [15:0] kd = '0;
    logic [14:0]        lim_drive = '0;
    logic [30:0]        lim_accum = '0;

    // mirrored controller state
    logic signed [31:0] integ = '0;
    logic signed [16:0] last_err = '0;
    logic signed [15:0] last_drive = '0;

    logic [15:0] drive_expected[$];

    // one control step: updates the mirrored state and returns the drive word
    function automatic logic [15:0] next_drive(input logic act, input logic signed [15:0] sp,
                                               input logic signed [15:0] ms);
        longint e, mag, acc, lim, p, i, d, sum;
        if (act == ACTION_CLEAR)
        begin
            integ      = '0;
            last_err   = '0;
            last_drive = '0;
            return 16'h0000;
        end
        e   = longint'(sp) - longint'(ms);
        mag = longint'(last_drive);
        if (mag < 0)
            mag = -mag;
        acc = longint'(integ);
        // conditional integration with 32-bit saturation
        if (mag < longint'(lim_drive))
        begin
            acc = acc + e;
            if (acc > ACC_MAX)
                acc = ACC_MAX;
            else if (acc < ACC_MIN)
                acc = ACC_MIN;
        end
        // integral clamp, zero limit leaves it open
        lim = longint'(lim_accum);
        if (lim != 0)
        begin
            if (acc > lim)
                acc = lim;
            else if (acc < -lim)
                acc = -lim;
        end
        p = (longint'(kp) * e) >>> 8;
        i = (longint'(ki) * acc) >>> 8;
        d = (longint'(kd) * (e - longint'(last_err))) >>> 8;
        sum = p + i + d;
        // output clamp, then 16-bit saturation
        lim = longint'(lim_drive);
        if (lim != 0)
        begin
            if (sum > lim)
                sum = lim;
            else if (sum < -lim)
                sum = -lim;
        end
        if (sum > 32767)
            sum = 32767;
        else if (sum < -32768)
            sum = -32768;
        integ      = acc[31:0];
        last_err   = e[16:0];
        last_drive = sum[15:0];
        return sum[15:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [15:0] want;
        if (!rst_n)
        begin
            kp         = '0;
            ki         = '0;
            kd         = '0;
            lim_drive  = '0;
            lim_accum  = '0;
            integ      = '0;
            last_err   = '0;
            last_drive = '0;
            drive_expected.delete();
            outstanding = 0;
        end
        else
        begin
            // drive word out: compare with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (outstanding == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected drive word %0d", $realtime,
                                 $signed(m_tdata));
                end
                else
                begin
                    want = drive_expected.pop_front();
                    outstanding--;
                    if (want !== m_tdata)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: drive expected %0d got %0d", $realtime,
                                     $signed(want), $signed(m_tdata));
                    end
                end
            end
            // update word in: predict its drive
            if (s_tvalid && s_tready)
            begin
                drive_expected.push_back(next_drive(s_tuser[0], s_tdata[15:0],
                                                    s_tdata[31:16]));
                outstanding++;
            end
            // register write, unknown indexes are dropped
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GAIN_P:      kp = cfg_data[15:0];
                    REG_GAIN_I:      ki = cfg_data[15:0];
                    REG_GAIN_D:      kd = cfg_data[15:0];
                    REG_DRIVE_LIMIT: lim_drive = cfg_data[14:0];
                    REG_ACCUM_LIMIT: lim_accum = cfg_data[30:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ sim/tb_top.sv @@
// tb_top: stimulus and verdict for pid_controller_antiwindup
// drives config and update words with random gaps and backpressure; pid_drive_monitor checks

`timescale 1ns / 100ps

module tb_top;

    import pidaw_pkg::*;

    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 116;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [31:0]            s_tdata;
    logic [0:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [15:0]            m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int mismatches;
    int outstanding;
    int stall_left;
    bit jitter_on = 1'b1;

    pid_controller_antiwindup uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pid_drive_monitor drive_mon (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // run limit
    initial
    begin
        #20000000;
        $display("tb_top: errors");
        $finish;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (!jitter_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // drive side backpressure
    initial
    begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (jitter_on && $urandom_range(0, 3) == 0)
            begin
                m_tready   <= 1'b0;
                stall_left = pick_gap();
            end
            else
                m_tready <= 1'b1;
        end
    end

    // send one update word, entered and left just after a falling edge
    task automatic send_word(input logic act, input logic [15:0] sp, input logic [15:0] ms);
        int n;
        n = pick_gap();
        repeat (n)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {ms, sp};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // hold the update channel until every drive word is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // one register write, leaves cfg_valid high
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    // full register setup on an idle block, junk bits above each field, optionally an unknown index write
    task automatic configure(input logic [15:0] gp, input logic [15:0] gi,
                             input logic [15:0] gd, input logic [14:0] dl,
                             input logic [30:0] al, input bit junk);
        logic [31:0] r;
        drain();
        r = $urandom();
        write_reg(REG_GAIN_P, {r[31:16], gp});
        r = $urandom();
        write_reg(REG_GAIN_I, {r[31:16], gi});
        r = $urandom();
        write_reg(REG_GAIN_D, {r[31:16], gd});
        r = $urandom();
        write_reg(REG_DRIVE_LIMIT, {r[31:15], dl});
        r = $urandom();
        write_reg(REG_ACCUM_LIMIT, {r[31], al});
        if (junk)
            write_reg(REG_ACCUM_LIMIT + CFG_INDEX_W'($urandom_range(1, 3)), $urandom());
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [15:0] rand_gain();
        if ($urandom_range(0, 1) == 0)
            return 16'($urandom_range(0, 2047) - 1024);
        return 16'($urandom());
    endfunction

    function automatic logic [14:0] rand_drive_limit();
        case ($urandom_range(0, 3))
            0: return 15'd0;
            1: return 15'($urandom_range(1, 2000));
            default: return 15'($urandom());
        endcase
    endfunction

    function automatic logic [30:0] rand_accum_limit();
        case ($urandom_range(0, 3))
            0: return 31'd0;
            1: return 31'($urandom_range(1, 100000));
            default: return 31'($urandom());
        endcase
    endfunction

    initial
    begin
        int ph;
        int k;
        int r;
        logic [15:0] sp;
        logic [15:0] ms;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: field extremes, clears
        configure(16'd256, 16'd32, 16'd128, 15'h7FFF, 31'd0, 1'b0);
        send_word(ACTION_CLEAR, 16'h0000, 16'h0000);
        send_word(ACTION_UPDATE, 16'h7FFF, 16'h8000);
        send_word(ACTION_UPDATE, 16'h8000, 16'h7FFF);
        send_word(ACTION_UPDATE, 16'h0000, 16'h0000);
        send_word(ACTION_UPDATE, 16'h7FFF, 16'h7FFF);
        send_word(ACTION_UPDATE, 16'h8000, 16'h8000);
        send_word(ACTION_UPDATE, 16'h0100, 16'h0000);
        send_word(ACTION_CLEAR, 16'($urandom()), 16'($urandom()));
        send_word(ACTION_UPDATE, 16'hFFFF, 16'h0001);

        // zero drive limit: no integration, no clamp
        configure(16'd300, 16'd200, 16'd50, 15'd0, 31'd0, 1'b0);
        send_word(ACTION_UPDATE, 16'h4000, 16'h0000);
        send_word(ACTION_UPDATE, 16'h4000, 16'h0000);
        send_word(ACTION_UPDATE, 16'h8000, 16'h7FFF);

        // extreme gains and tightest limits, plus an unknown index write
        configure(16'h8000, 16'h7FFF, 16'h8000, 15'd1, 31'd1, 1'b1);
        send_word(ACTION_UPDATE, 16'h7FFF, 16'h8000);
        send_word(ACTION_UPDATE, 16'h0000, 16'h0001);
        send_word(ACTION_UPDATE, 16'h8000, 16'h7FFF);
        send_word(ACTION_UPDATE, 16'h0001, 16'h0000);

        configure(16'h7FFF, 16'h8000, 16'h7FFF, 15'h7FFF, 31'h7FFFFFFF, 1'b1);
        send_word(ACTION_UPDATE, 16'h7FFF, 16'h8000);
        send_word(ACTION_UPDATE, 16'h8000, 16'h7FFF);
        send_word(ACTION_UPDATE, 16'h1234, 16'h0FED);
        send_word(ACTION_CLEAR, 16'hFFFF, 16'hFFFF);

        // random phases, several register settings
        for (ph = 0; ph < PHASES; ph++)
        begin
            jitter_on = (ph != 3);
            case (ph)
                0: configure(16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h7FFF, 31'h7FFFFFFF, 1'b0);
                1: configure(16'h8000, 16'h8000, 16'h8000, 15'd1, 31'd1, 1'b1);
                2: configure(rand_gain(), rand_gain(), rand_gain(), 15'd0, 31'd0, 1'b0);
                default: configure(rand_gain(), rand_gain(), rand_gain(), rand_drive_limit(),
                                   rand_accum_limit(), 1'($urandom_range(0, 1)));
            endcase
            for (k = 0; k < PHASE_LEN; k++)
            begin
                // now and then the sender holds off until the pipeline is empty
                if ($urandom_range(0, 49) == 0)
                    drain();
                r  = $urandom_range(0, 19);
                sp = 16'($urandom());
                if (r < 2)
                    send_word(ACTION_CLEAR, sp, 16'($urandom()));
                else if (r < 10)
                    send_word(ACTION_UPDATE, sp, 16'($urandom()));
                else
                begin
                    ms = sp + 16'($urandom_range(0, 1023) - 512);
                    send_word(ACTION_UPDATE, sp, ms);
                end
            end
        end

        // wait out the tail and give the verdict
        drain();
        repeat (8) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
